/* rtl/pnc_pkg.sv */
// Shared types and constants for the palette nearest color search block.
`timescale 1ns / 1ps

package pnc_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int COLOR_W     = 8;
  localparam int INDEX_SPAN  = 256;
  localparam int SQ_W        = 2 * COLOR_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int VERSION_W   = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } scan_tag_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } seq_state_t;

endpackage

/* rtl/pnc_store.sv */
// Palette store: single write port, single registered read port.
`timescale 1ns / 1ps

module pnc_store #(
  parameter int ENTRIES = pnc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pnc_pkg::store_ctl_t ctl,
  input  logic [((ENTRIES < pnc_pkg::INDEX_SPAN) ? $clog2(ENTRIES)
                 : $clog2(pnc_pkg::INDEX_SPAN))-1:0] waddr,
  input  pnc_pkg::rgb_t       wdata,
  input  logic [IDX_W-1:0]    raddr,
  input  pnc_pkg::scan_tag_t  rd_tag,
  output pnc_pkg::scan_tag_t  rd_tag_r,
  output logic [IDX_W-1:0]    rd_idx_r,
  output pnc_pkg::rgb_t       rd_data
);

  localparam int DEPTH = (ENTRIES < pnc_pkg::INDEX_SPAN) ? ENTRIES : pnc_pkg::INDEX_SPAN;
  localparam int AW    = $clog2(DEPTH);

  pnc_pkg::rgb_t mem [DEPTH];
  pnc_pkg::rgb_t rd_raw_r;
  logic          rd_hi_r;
  logic          in_range;

  assign in_range = 32'(raddr) < DEPTH;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rd_raw_r <= mem[raddr[AW-1:0]];
      rd_hi_r  <= !in_range;
      rd_idx_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r.valid <= ctl.re && rd_tag.valid;
      rd_tag_r.last  <= ctl.re && rd_tag.last;
    end
  end

  assign rd_data = rd_hi_r ? '0 : rd_raw_r;

endmodule

/* rtl/pnc_dist.sv */
// Two-stage squared RGB distance unit shared by every entry of a scan.
`timescale 1ns / 1ps

module pnc_dist #(
  parameter int IDX_W = $clog2(pnc_pkg::ENTRIES_DEF)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pnc_pkg::scan_tag_t             tag,
  input  logic [IDX_W-1:0]               idx,
  input  pnc_pkg::rgb_t                  entry,
  input  pnc_pkg::rgb_t                  query,
  output pnc_pkg::scan_tag_t             dist_tag_r,
  output logic [IDX_W-1:0]               dist_idx_r,
  output logic [pnc_pkg::DIST_W-1:0]     dist_r
);

  logic [pnc_pkg::COLOR_W-1:0] d_red, d_green, d_blue;
  logic [pnc_pkg::SQ_W-1:0]    sq_red_r, sq_green_r, sq_blue_r;
  pnc_pkg::scan_tag_t          sq_tag_r;
  logic [IDX_W-1:0]            sq_idx_r;

  assign d_red   = (query.red >= entry.red) ? query.red - entry.red : entry.red - query.red;
  assign d_green = (query.green >= entry.green) ? query.green - entry.green
                                                : entry.green - query.green;
  assign d_blue  = (query.blue >= entry.blue) ? query.blue - entry.blue
                                              : entry.blue - query.blue;

  always_ff @(posedge clk) begin
    sq_red_r   <= pnc_pkg::SQ_W'(d_red) * pnc_pkg::SQ_W'(d_red);
    sq_green_r <= pnc_pkg::SQ_W'(d_green) * pnc_pkg::SQ_W'(d_green);
    sq_blue_r  <= pnc_pkg::SQ_W'(d_blue) * pnc_pkg::SQ_W'(d_blue);
    sq_idx_r   <= idx;
    dist_r     <= pnc_pkg::DIST_W'(sq_red_r) + pnc_pkg::DIST_W'(sq_green_r)
                + pnc_pkg::DIST_W'(sq_blue_r);
    dist_idx_r <= sq_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r   <= '0;
      dist_tag_r <= '0;
    end else begin
      sq_tag_r   <= tag;
      dist_tag_r <= sq_tag_r;
    end
  end

endmodule

/* rtl/pnc_best.sv */
// Running minimum tracker: keeps the first index with the least distance.
`timescale 1ns / 1ps

module pnc_best #(
  parameter int IDX_W = $clog2(pnc_pkg::ENTRIES_DEF)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  pnc_pkg::scan_tag_t         tag,
  input  logic [IDX_W-1:0]           idx,
  input  logic [pnc_pkg::DIST_W-1:0] cand_dist,
  output logic                       done_r,
  output logic [IDX_W-1:0]           best_idx_r
);

  logic [pnc_pkg::DIST_W-1:0] best_dist_r;

  always_ff @(posedge clk) begin
    if (start) begin
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (tag.valid && (cand_dist < best_dist_r)) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= tag.valid && tag.last;
    end
  end

endmodule

/* rtl/palette_nearest_color_search_top.sv */
// Palette nearest color search: top level with sequencer, version counter and result register.
// After reset the block clears its palette store to black, one entry per cycle, for
// min(ENTRIES, 256) entries; it stalls its input until then. A write beat gives no result.
// A query beat scans every entry through one store read port and one distance unit,
// one entry per cycle; the next beat is taken once the result sits in the output register.
`timescale 1ns / 1ps

module palette_nearest_color_search_top #(
  parameter int ENTRIES = pnc_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_load_done,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_nearest_index,
  output logic [31:0] out_palette_version
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int DEPTH = (ENTRIES < pnc_pkg::INDEX_SPAN) ? ENTRIES : pnc_pkg::INDEX_SPAN;
  localparam int AW    = $clog2(DEPTH);

  pnc_pkg::seq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  pnc_pkg::rgb_t       query_r, query_nxt;
  logic [pnc_pkg::VERSION_W-1:0] version_r, version_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_index_r, out_index_nxt;
  logic [pnc_pkg::VERSION_W-1:0] out_version_r, out_version_nxt;

  logic                in_accept;
  logic                best_start;
  pnc_pkg::store_ctl_t st_ctl;
  logic [AW-1:0]       st_waddr;
  pnc_pkg::rgb_t       st_wdata;
  pnc_pkg::scan_tag_t  rd_tag;
  pnc_pkg::scan_tag_t  rd_tag_r;
  logic [IDX_W-1:0]    rd_idx_r;
  pnc_pkg::rgb_t       rd_data;
  pnc_pkg::scan_tag_t  dist_tag_r;
  logic [IDX_W-1:0]    dist_idx_r;
  logic [pnc_pkg::DIST_W-1:0] dist_r;
  logic                best_done;
  logic [IDX_W-1:0]    best_idx;
  logic                out_free;
  pnc_pkg::rgb_t       in_color;

  assign in_stall  = (state_r != pnc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_color  = '{red: in_red, green: in_green, blue: in_blue};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnc_pkg::ST_CLEAR;
      addr_r      <= '0;
      version_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      version_r   <= version_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r       <= query_nxt;
    out_index_r   <= out_index_nxt;
    out_version_r <= out_version_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    query_nxt       = query_r;
    version_nxt     = version_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_index_nxt   = out_index_r;
    out_version_nxt = out_version_r;
    best_start      = 1'b0;
    st_ctl          = '0;
    st_waddr        = AW'(in_entry_index);
    st_wdata        = in_color;
    rd_tag          = '0;
    unique case (state_r)
      pnc_pkg::ST_CLEAR: begin
        st_ctl.we = 1'b1;
        st_waddr  = addr_r[AW-1:0];
        st_wdata  = '0;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == IDX_W'(DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = pnc_pkg::ST_IDLE;
        end
      end
      pnc_pkg::ST_IDLE: begin
        if (in_accept && (in_opcode == pnc_pkg::OP_WRITE)) begin
          st_ctl.we = 32'(in_entry_index) < DEPTH;
          if (in_load_done) begin
            version_nxt = version_r + 1'b1;
          end
        end else if (in_accept && (in_opcode == pnc_pkg::OP_QUERY)) begin
          query_nxt  = in_color;
          addr_nxt   = '0;
          best_start = 1'b1;
          state_nxt  = pnc_pkg::ST_SCAN;
        end
      end
      pnc_pkg::ST_SCAN: begin
        st_ctl.re    = 1'b1;
        rd_tag.valid = 1'b1;
        rd_tag.last  = (addr_r == IDX_W'(ENTRIES - 1));
        addr_nxt     = addr_r + 1'b1;
        if (rd_tag.last) begin
          addr_nxt  = '0;
          state_nxt = pnc_pkg::ST_DRAIN;
        end
      end
      pnc_pkg::ST_DRAIN: begin
        if (best_done) begin
          state_nxt = pnc_pkg::ST_OUT;
        end
      end
      pnc_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_index_nxt   = 8'(best_idx);
          out_version_nxt = version_r;
          state_nxt       = pnc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pnc_pkg::ST_IDLE;
      end
    endcase
  end

  pnc_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (st_ctl),
    .waddr    (st_waddr),
    .wdata    (st_wdata),
    .raddr    (addr_r),
    .rd_tag   (rd_tag),
    .rd_tag_r (rd_tag_r),
    .rd_idx_r (rd_idx_r),
    .rd_data  (rd_data)
  );

  pnc_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (rd_tag_r),
    .idx        (rd_idx_r),
    .entry      (rd_data),
    .query      (query_r),
    .dist_tag_r (dist_tag_r),
    .dist_idx_r (dist_idx_r),
    .dist_r     (dist_r)
  );

  pnc_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (best_start),
    .tag        (dist_tag_r),
    .idx        (dist_idx_r),
    .cand_dist  (dist_r),
    .done_r     (best_done),
    .best_idx_r (best_idx)
  );

  assign out_valid           = out_valid_r;
  assign out_nearest_index   = out_index_r;
  assign out_palette_version = out_version_r;

`ifndef SYNTHESIS
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    best_done |-> (state_r == pnc_pkg::ST_DRAIN))
    else $error("scan finished outside drain");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.we |-> (state_r == pnc_pkg::ST_CLEAR || state_r == pnc_pkg::ST_IDLE))
    else $error("store written during a scan");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == pnc_pkg::ST_OUT))
    else $error("result raised outside output state");

  a_version_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (version_r != $past(version_r)) |->
      $past(in_accept && (in_opcode == pnc_pkg::OP_WRITE) && in_load_done))
    else $error("version moved without a load mark");
`endif

endmodule
